// ===== rtl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg: shared constants and types
// digit counts, ascii codes and the separator rule for the decimal printer
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGITS   = 10;
    localparam int POS_W    = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_COMMA = 8'h2C;

    // packed bcd digits, index 0 holds the units digit
    typedef logic [DIGITS-1:0][3:0] digits_t;

    // position counts from the billions digit (0) down to the units digit
    localparam logic [POS_W-1:0] POS_BILLIONS  = 4'd0;
    localparam logic [POS_W-1:0] POS_MILLIONS  = 4'd3;
    localparam logic [POS_W-1:0] POS_THOUSANDS = 4'd6;
    localparam logic [POS_W-1:0] POS_UNITS     = 4'd9;

    // a separator follows the billions, millions and thousands digits
    function automatic logic comma_after(input logic [POS_W-1:0] pos);
        return (pos == POS_BILLIONS) || (pos == POS_MILLIONS) || (pos == POS_THOUSANDS);
    endfunction

endpackage

// ===== rtl/dtc_bcd.sv =====
// ----------------------------------------------------------------------------
// dtc_bcd: pipelined binary to bcd converter
// shift-and-add-three over eight stages, four input bits per stage
// ----------------------------------------------------------------------------
module dtc_bcd
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dtc_pkg::VALUE_W-1:0]      in_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output dtc_pkg::digits_t                 out_digits
);

    localparam int BITS_PER_STAGE = 4;
    localparam int STAGES         = dtc_pkg::VALUE_W / BITS_PER_STAGE;
    localparam int BCD_W          = 4 * dtc_pkg::DIGITS;

    // one stage worth of shift-and-add-three
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic [BITS_PER_STAGE-1:0] bits);
        logic [BCD_W-1:0] b;
        b = bcd;
        for (int j = BITS_PER_STAGE - 1; j >= 0; j--)
        begin
            for (int d = 0; d < dtc_pkg::DIGITS; d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[j]};
        end
        return b;
    endfunction

    logic [STAGES-1:0]               valid_reg;
    logic [BCD_W-1:0]                bcd_reg [STAGES];
    logic [dtc_pkg::VALUE_W-1:0]     bin_reg [STAGES];
    logic [STAGES:0]                 advance;

    // a stage moves when it is empty or the one after it moves
    assign advance[STAGES] = out_ready;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic                         src_valid;
            logic [BCD_W-1:0]             src_bcd;
            logic [dtc_pkg::VALUE_W-1:0]  src_bin;

            assign advance[k] = !valid_reg[k] || advance[k+1];

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_bcd   = '0;
                assign src_bin   = in_value;
            end
            else
            begin : g_rest
                assign src_valid = valid_reg[k-1];
                assign src_bcd   = bcd_reg[k-1];
                assign src_bin   = bin_reg[k-1];
            end

            // valid bit of the stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (advance[k])
                begin
                    valid_reg[k] <= src_valid;
                end
            end

            // digits and remaining binary bits
            always_ff @(posedge clk)
            begin
                if (advance[k])
                begin
                    bcd_reg[k] <= dabble(src_bcd,
                        src_bin[dtc_pkg::VALUE_W-1 -: BITS_PER_STAGE]);
                    bin_reg[k] <= {src_bin[dtc_pkg::VALUE_W-BITS_PER_STAGE-1:0],
                                   {BITS_PER_STAGE{1'b0}}};
                end
            end
        end
    endgenerate

    assign in_ready   = advance[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign out_digits = dtc_pkg::digits_t'(bcd_reg[STAGES-1]);

    // the top and units digits leaving the converter are decimal digits
    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_digits[dtc_pkg::DIGITS-1] <= 4'd9) && (out_digits[0] <= 4'd9))
        else $error("bcd digit out of range");

endmodule

// ===== rtl/dtc_ser.sv =====
// ----------------------------------------------------------------------------
// dtc_ser: character serialiser
// walks the digits of one value and, while the output register is free, emits digits and separators, one a cycle
// ----------------------------------------------------------------------------
module dtc_ser
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dtc_pkg::digits_t               in_digits,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dtc_pkg::CHAR_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    logic                           busy_reg, busy_next;
    logic                           comma_reg, comma_next;
    logic [dtc_pkg::POS_W-1:0]      pos_reg, pos_next;
    dtc_pkg::digits_t               dig_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [dtc_pkg::CHAR_W-1:0]     out_char_reg;
    logic                           out_last_reg;

    logic                           slot_free;
    logic                           emit;
    logic                           emit_last;
    logic                           load;
    logic [dtc_pkg::POS_W-1:0]      lead;
    logic [3:0]                     cur_digit;
    logic [dtc_pkg::CHAR_W-1:0]     cur_char;

    // output register is free when empty or being taken
    assign slot_free = !out_valid_reg || m_tready;
    assign emit      = busy_reg && slot_free;
    assign emit_last = !comma_reg && (pos_reg == dtc_pkg::POS_UNITS);
    assign in_ready  = !busy_reg || (emit && emit_last);
    assign load      = in_valid && in_ready;

    // first nonzero digit, units digit when the value is zero
    always_comb
    begin
        lead = dtc_pkg::POS_UNITS;
        for (int p = dtc_pkg::DIGITS - 1; p >= 0; p--)
        begin
            if (in_digits[dtc_pkg::DIGITS-1-p] != 4'd0)
            begin
                lead = dtc_pkg::POS_W'(p);
            end
        end
    end

    // character at the current position
    assign cur_digit = dig_reg[dtc_pkg::POS_UNITS - pos_reg];
    assign cur_char  = comma_reg ? dtc_pkg::ASCII_COMMA
                                 : (dtc_pkg::ASCII_ZERO + {4'd0, cur_digit});

    // walk through digits and separators
    always_comb
    begin
        busy_next  = busy_reg;
        comma_next = comma_reg;
        pos_next   = pos_reg;
        if (emit)
        begin
            priority if (comma_reg)
            begin
                comma_next = 1'b0;
                pos_next   = pos_reg + 4'd1;
            end
            else if (emit_last)
            begin
                busy_next = 1'b0;
            end
            else if (dtc_pkg::comma_after(pos_reg))
            begin
                comma_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            comma_next = 1'b0;
            pos_next   = lead;
        end
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            comma_reg     <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            comma_reg     <= comma_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dig_reg <= in_digits;
        end
        if (emit)
        begin
            out_char_reg <= cur_char;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // a pending separator only follows a separator position
    a_comma_pos: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && comma_reg |-> dtc_pkg::comma_after(pos_reg))
        else $error("separator pending at wrong position");

    // the final word of a value is never a separator
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_char_reg != dtc_pkg::ASCII_COMMA)
        else $error("value text ends in a separator");

    // the position never runs past the units digit
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg <= dtc_pkg::POS_UNITS)
        else $error("digit position out of range");

endmodule

// ===== rtl/decimal_with_thousands_commas_top.sv =====
// ----------------------------------------------------------------------------
// decimal_with_thousands_commas_top: decimal text printer
// unsigned 32-bit value in, ascii digits with thousands separators out
// ----------------------------------------------------------------------------
// usage
//   s_* takes one unsigned 32-bit value per word (tvalid/tready handshake).
//   m_* gives the decimal text, one ascii character per word, most
//   significant digit first, leading zeros dropped, a comma after the
//   billions, millions and thousands digits once a nonzero digit has been
//   seen; tlast marks the units digit. zero prints as a single '0'.
// pipeline and throughput
//   the first character of a value passes eight converter stages of four
//   bits each, a load into the serialiser and the output register. the
//   serialiser then gives one character per cycle while m_tready is high,
//   1 to 13 characters per value, set by the single character output;
//   values queue in the converter meanwhile and follow with no gap.
// reset and stalls
//   rst_n clears all valid bits; no word is pending after reset. when m_tready
//   is low the output word holds, the serialiser and converter stages fill
//   and s_tready drops once every stage is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module decimal_with_thousands_commas_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // [31:0] value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,    // [7:0] character
    output logic         m_tlast
);

    logic              bcd_valid;
    logic              bcd_ready;
    dtc_pkg::digits_t  bcd_digits;

    // binary to bcd pipeline
    dtc_bcd u_bcd
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata),
        .out_valid  (bcd_valid),
        .out_ready  (bcd_ready),
        .out_digits (bcd_digits)
    );

    // digits and separators onto the output
    dtc_ser u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bcd_valid),
        .in_ready   (bcd_ready),
        .in_digits  (bcd_digits),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: decimal text printer testbench
// sends unsigned 32-bit values on the input stream, works out the expected
// ascii text with thousands separators for each accepted value and checks
// every output word in order; both sides idle at random and the output is
// held off for a long stretch so the block fills up and stalls its input
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLD_CYCLES  = 400;

    // one expected output word
    typedef struct packed {
        logic [dtc_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } text_char_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [dtc_pkg::VALUE_W-1:0]   s_tdata  = '0;     // [31:0] value
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dtc_pkg::CHAR_W-1:0]    m_tdata;           // [7:0] character
    logic                          m_tlast;

    text_char_t chars_due[$];
    int         errors      = 0;
    int         cycles      = 0;
    bit         tx_idle_en  = 1'b1;
    bit         rx_idle_en  = 1'b1;
    int         hold_req    = 0;
    int         hold_left   = 0;
    int         rx_gap_left = 0;

    decimal_with_thousands_commas_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d characters still due", $time, chars_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // decimal text of one value, queued as expected words
    function automatic void predict_text(input logic [dtc_pkg::VALUE_W-1:0] value);
        logic [dtc_pkg::VALUE_W-1:0] rest;
        logic [dtc_pkg::VALUE_W-1:0] place;
        logic [3:0]                  digit;
        bit                          started;
        text_char_t                  txt[$];
        text_char_t                  c;
        rest    = value;
        place   = 32'd1000000000;
        started = 1'b0;
        if (value == '0)
        begin
            c.ch   = dtc_pkg::ASCII_ZERO;
            c.last = 1'b0;
            txt.push_back(c);
        end
        else
        begin
            for (int pos = 0; pos < dtc_pkg::DIGITS; pos++)
            begin
                digit = 4'(rest / place);
                rest  = rest % place;
                place = place / 10;
                if (digit != 4'd0)
                    started = 1'b1;
                if (started)
                begin
                    c.ch   = dtc_pkg::ASCII_ZERO + {4'd0, digit};
                    c.last = 1'b0;
                    txt.push_back(c);
                    // separator after billions, millions and thousands
                    if (pos == int'(dtc_pkg::POS_BILLIONS) ||
                        pos == int'(dtc_pkg::POS_MILLIONS) ||
                        pos == int'(dtc_pkg::POS_THOUSANDS))
                    begin
                        c.ch = dtc_pkg::ASCII_COMMA;
                        txt.push_back(c);
                    end
                end
            end
        end
        txt[txt.size()-1].last = 1'b1;
        foreach (txt[i])
            chars_due.push_back(txt[i]);
    endfunction

    // random value, spread over digit counts and awkward zero patterns
    function automatic logic [dtc_pkg::VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint p;
        int     n;
        int     sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3:
            begin
                n  = $urandom_range(1, dtc_pkg::DIGITS);
                lo = 1;
                for (int i = 1; i < n; i++)
                    lo = lo * 10;
                hi = lo * 10 - 1;
                if (n == 1)
                    lo = 0;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                return 32'($urandom_range(32'(hi), 32'(lo)));
            end
            4, 5:
                return $urandom;
            6:
            begin
                // interior zero groups
                p = 1;
                n = $urandom_range(3, 9);
                for (int i = 0; i < n; i++)
                    p = p * 10;
                lo = longint'($urandom_range(1, 42)) * p + $urandom_range(0, 9);
                if (lo > 64'hFFFF_FFFF)
                    lo = p;
                return 32'(lo);
            end
            7:
                return 32'($urandom_range(0, 20));
            8:
            begin
                // near a power of ten
                p = 1;
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    p = p * 10;
                return 32'(p + $urandom_range(0, 6) - 3);
            end
            default:
                return 32'hFFFF_FFFF - $urandom_range(0, 100);
        endcase
    endfunction

    // send one value word and wait for it to be taken
    task automatic send_value(input logic [dtc_pkg::VALUE_W-1:0] value);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_text(value);
    endtask

    // drop valid
    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (chars_due.size() != 0)
            @(posedge clk);
    endtask

    // receiver: check each word, then decide on ready for the next cycle
    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (m_tvalid === 1'b1 && m_tready)
        begin
            if (chars_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual char %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                exp_c = chars_due.pop_front();
                if (m_tdata !== exp_c.ch)
                begin
                    $display("%0t: char mismatch, expected %h, actual %h",
                             $time, exp_c.ch, m_tdata);
                    errors++;
                end
                if (m_tlast !== exp_c.last)
                begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, exp_c.last, m_tlast);
                    errors++;
                end
            end
        end
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_gap_left > 0)
        begin
            rx_gap_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            rx_gap_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // field extremes, digit count boundaries and zero patterns
    task automatic test_directed();
        logic [dtc_pkg::VALUE_W-1:0] vals[$];
        vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                 32'd9999, 32'd10000, 32'd999999, 32'd1000000, 32'd1000001,
                 32'd999999999, 32'd1000000000, 32'd1001001001, 32'd100000000,
                 32'd12345, 32'd4000000000, 32'h8000_0000, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hFFFF_FFFF, 32'd0};
        foreach (vals[i])
            send_value(vals[i]);
        stop_sending();
    endtask

    // random values with idling on both sides
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_value(random_value());
        stop_sending();
    endtask

    // long receiver hold-off while values keep coming, then a full drain
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_req   = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_value(i[0] ? 32'hFFFF_FFFF - i : random_value());
        stop_sending();
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    // back to back with no idling at all
    task automatic test_no_idle(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < count; i++)
            send_value(random_value());
        stop_sending();
    endtask

    // sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400);
        test_backpressure();
        test_no_idle(60);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && chars_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dtc_pkg.sv
rtl/dtc_bcd.sv
rtl/dtc_ser.sv
rtl/decimal_with_thousands_commas_top.sv
verif/tb_top.sv
